// File: design/lmts_pkg.sv
// ----------------------------------------------------------------------------
// lmts_pkg - LCD mode timing sequencer definitions
// Mode codes, phase durations, line limits, interrupt enable bits and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package lmts_pkg;

   // LCD status mode codes
   typedef enum logic [1:0] {
      MODE_HBLANK = 2'd0,
      MODE_VBLANK = 2'd1,
      MODE_OAM    = 2'd2,
      MODE_XFER   = 2'd3
   } mode_type;

   // phase durations in machine cycles
   localparam logic [15:0] DUR_HBLANK = 16'd51;
   localparam logic [15:0] DUR_VLINE  = 16'd114;
   localparam logic [15:0] DUR_OAM    = 16'd20;
   localparam logic [15:0] DUR_XFER   = 16'd43;

   // line limits
   localparam logic [7:0] LINE_VBLANK = 8'd144;
   localparam logic [7:0] LINE_LAST   = 8'd153;

   // interrupt enable bit positions
   localparam int EN_HBLANK = 0;
   localparam int EN_VBLANK = 1;
   localparam int EN_OAM    = 2;
   localparam int EN_LYC    = 3;

   // configuration register indexes
   localparam logic [7:0] CSR_STAT_IRQ_ENABLES = 8'd0;
   localparam logic [7:0] CSR_COMPARE_LINE     = 8'd1;

endpackage : lmts_pkg

`default_nettype wire

// File: design/lcd_mode_timing_sequencer.sv
// ----------------------------------------------------------------------------
// lcd_mode_timing_sequencer - LCD status mode and scan line timing
// Accumulates elapsed machine cycles, steps through OAM search, transfer,
// H-blank and V-blank lines, tracks the scan line and raises interrupts.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  req_     | in        | req_valid / req_stall  | elapsed_cycles[4:0]
//  rsp_     | out       | rsp_valid / rsp_stall  | lcd_mode, current_line,
//           |           |                        | coincidence, pulses
//  csr_     | in        | csr_valid / csr_ready  | csr_index[7:0], csr_data[7:0]
//
//  One item per clock while req_stall is low; each result appears in the next cycle.
//  The accumulate, compare and subtract path lies between the state registers
//  and the result register. csr_ready is always high.
//  Synchronous active-high reset clears all state except the result payload.
//  req_stall is high only while a result is held and rsp_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_mode_timing_sequencer (
   input  wire logic       clock,
   input  wire logic       reset,
   // tick items
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [4:0] req_elapsed_cycles,
   // result items
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [1:0]      rsp_lcd_mode,
   output logic [7:0]      rsp_current_line,
   output logic            rsp_coincidence,
   output logic            rsp_vblank_irq,
   output logic            rsp_lcd_irq,
   output logic            rsp_render_line,
   // configuration writes
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_index,
   input  wire logic [7:0] csr_data
);

   // state
   logic [15:0]             accum_ff, accum_in;
   lmts_pkg::mode_type      mode_ff, mode_in;
   logic [7:0]              line_ff, line_in;
   logic                    coin_ff, coin_in;
   logic [3:0]              enables_ff;
   logic [7:0]              compare_ff;

   // result register
   logic                    rsp_valid_ff;
   logic [1:0]              rsp_mode_ff;
   logic [7:0]              rsp_line_ff;
   logic                    rsp_coin_ff;
   logic                    rsp_vb_ff, rsp_vb_in;
   logic                    rsp_lcd_ff, rsp_lcd_in;
   logic                    rsp_render_ff, rsp_render_in;

   logic                    req_accept;
   logic [16:0]             sum_w;
   logic [15:0]             accum_sat;
   logic [15:0]             dur;
   logic                    done;
   logic [7:0]              line_inc;
   logic                    line_eq;

   // handshake: the result register frees up when its item is taken
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = 1'b1;

   // saturating accumulate and phase-end test
   assign sum_w     = {1'b0, accum_ff} + 17'(req_elapsed_cycles);
   assign accum_sat = sum_w[16] ? 16'hFFFF : sum_w[15:0];
   assign line_inc  = line_ff + 8'd1;
   assign line_eq   = (line_inc == compare_ff);

   always_comb begin
      case (mode_ff)
         lmts_pkg::MODE_HBLANK: dur = lmts_pkg::DUR_HBLANK;
         lmts_pkg::MODE_VBLANK: dur = lmts_pkg::DUR_VLINE;
         lmts_pkg::MODE_OAM:    dur = lmts_pkg::DUR_OAM;
         default:               dur = lmts_pkg::DUR_XFER;
      endcase
   end

   assign done = (accum_sat >= dur);

   // next state
   always_comb begin
      accum_in = accum_sat;
      mode_in  = mode_ff;
      line_in  = line_ff;
      coin_in  = coin_ff;
      if (done) begin
         accum_in = accum_sat - dur;
         case (mode_ff)
            lmts_pkg::MODE_HBLANK: begin
               line_in = line_inc;
               coin_in = line_eq;
               mode_in = (line_inc == lmts_pkg::LINE_VBLANK) ?
                         lmts_pkg::MODE_VBLANK : lmts_pkg::MODE_OAM;
            end
            lmts_pkg::MODE_VBLANK: begin
               coin_in = line_eq;
               if (line_inc == lmts_pkg::LINE_LAST) begin
                  line_in = 8'd0;
                  mode_in = lmts_pkg::MODE_OAM;
               end else begin
                  line_in = line_inc;
               end
            end
            lmts_pkg::MODE_OAM: mode_in = lmts_pkg::MODE_XFER;
            default:            mode_in = lmts_pkg::MODE_HBLANK;
         endcase
      end
   end

   // pulse outputs
   always_comb begin
      rsp_vb_in     = 1'b0;
      rsp_lcd_in    = 1'b0;
      rsp_render_in = 1'b0;
      if (done) begin
         case (mode_ff)
            lmts_pkg::MODE_HBLANK: begin
               rsp_vb_in = (line_inc == lmts_pkg::LINE_VBLANK);
               // entering V-blank raises the V-blank enable, not the OAM one
               rsp_lcd_in = (line_eq & enables_ff[lmts_pkg::EN_LYC]) |
                            (rsp_vb_in ? enables_ff[lmts_pkg::EN_VBLANK]
                                       : enables_ff[lmts_pkg::EN_OAM]);
            end
            lmts_pkg::MODE_VBLANK: begin
               rsp_lcd_in = (line_eq & enables_ff[lmts_pkg::EN_LYC]) |
                            ((line_inc == lmts_pkg::LINE_LAST) &
                             enables_ff[lmts_pkg::EN_OAM]);
            end
            lmts_pkg::MODE_OAM: rsp_lcd_in = 1'b0;
            default: begin
               rsp_render_in = 1'b1;
               rsp_lcd_in    = enables_ff[lmts_pkg::EN_HBLANK];
            end
         endcase
      end
   end

   // state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff   <= '0;
         mode_ff    <= lmts_pkg::MODE_HBLANK;
         line_ff    <= '0;
         coin_ff    <= 1'b0;
         enables_ff <= '0;
         compare_ff <= '0;
      end else begin
         if (req_accept) begin
            accum_ff <= accum_in;
            mode_ff  <= mode_in;
            line_ff  <= line_in;
            coin_ff  <= coin_in;
         end
         if (csr_valid) begin
            case (csr_index)
               lmts_pkg::CSR_STAT_IRQ_ENABLES: enables_ff <= csr_data[3:0];
               lmts_pkg::CSR_COMPARE_LINE:     compare_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_mode_ff   <= mode_in;
         rsp_line_ff   <= line_in;
         rsp_coin_ff   <= coin_in;
         rsp_vb_ff     <= rsp_vb_in;
         rsp_lcd_ff    <= rsp_lcd_in;
         rsp_render_ff <= rsp_render_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_lcd_mode     = rsp_mode_ff;
   assign rsp_current_line = rsp_line_ff;
   assign rsp_coincidence  = rsp_coin_ff;
   assign rsp_vblank_irq   = rsp_vb_ff;
   assign rsp_lcd_irq      = rsp_lcd_ff;
   assign rsp_render_line  = rsp_render_ff;

   // checks
   a_line_range : assert property (@(posedge clock) disable iff (reset)
      line_ff <= lmts_pkg::LINE_LAST)
      else $error("scan line beyond last line");

   a_render_mode : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_render_ff) |-> (rsp_mode_ff == lmts_pkg::MODE_HBLANK))
      else $error("render pulse outside H-blank entry");

   a_vblank_entry : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_vb_ff) |->
         (rsp_mode_ff == lmts_pkg::MODE_VBLANK && rsp_line_ff == lmts_pkg::LINE_VBLANK))
      else $error("V-blank pulse not at V-blank entry");

   a_stall_held : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with empty result register");

   a_accum_step : assert property (@(posedge clock) disable iff (reset)
      (req_accept && !done) |=> (accum_ff >= $past(accum_ff)))
      else $error("accumulator dropped without a phase end");

endmodule : lcd_mode_timing_sequencer

`default_nettype wire

// File: tb/tb_lcd_mode_timing_sequencer.sv
// ----------------------------------------------------------------------------
// tb_lcd_mode_timing_sequencer - self-checking bench for the LCD mode timer
// Feeds tick items of elapsed machine cycles, mirrors the mode, line and
// interrupt behavior in a local model, and checks every status item field by
// field. Enable and compare settings change between phases while the block
// is idle; both channels see random gaps, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_lcd_mode_timing_sequencer;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 3;
   localparam int PHASE_ITEMS   = 70;
   localparam int HOLD_AT_ITEM  = 200;
   localparam int HOLD_CYCLES   = 300;

   typedef enum logic {OP_TICK, OP_CSR} op_kind_type;

   typedef struct {
      op_kind_type kind;
      logic [4:0]  ticks;
      logic [7:0]  index;
      logic [7:0]  data;
   } pending_op_type;

   typedef struct packed {
      lmts_pkg::mode_type mode;
      logic [7:0]         line;
      logic               coinc;
      logic               vblank;
      logic               lcd;
      logic               render;
   } lcd_status_type;

   // clock, reset and block inputs, all known from time zero
   logic       clock              = 1'b0;
   logic       reset              = 1'b1;
   logic       req_valid          = 1'b0;
   logic [4:0] req_elapsed_cycles = '0;
   logic       rsp_stall          = 1'b0;
   logic       csr_valid          = 1'b0;
   logic [7:0] csr_index          = '0;
   logic [7:0] csr_data           = '0;

   logic       req_stall;
   logic       rsp_valid;
   logic [1:0] rsp_lcd_mode;
   logic [7:0] rsp_current_line;
   logic       rsp_coincidence;
   logic       rsp_vblank_irq;
   logic       rsp_lcd_irq;
   logic       rsp_render_line;
   logic       csr_ready;

   // local copy of the timing state and settings
   logic [15:0]        acc_cycles  = '0;
   lmts_pkg::mode_type pred_mode   = lmts_pkg::MODE_HBLANK;
   logic [7:0]         pred_line   = '0;
   logic               pred_coinc  = 1'b0;
   logic [3:0]         cfg_enables = '0;
   logic [7:0]         cfg_compare = '0;

   pending_op_type pending_ops[$];
   lcd_status_type line_status_q[$];

   int mismatches    = 0;
   int results_seen  = 0;
   int cycle_count   = 0;
   int tick_gap      = 0;
   int tx_quiet      = 0;
   int stall_gap     = 0;
   int rx_quiet      = 0;
   int hold_left     = 0;
   int settle_count  = 0;

   // directed opening: zero and full ticks, each single bit, a few lines deep
   logic [4:0] opening_ticks [20] = '{5'd0, 5'd31, 5'd31, 5'd16, 5'd31, 5'd8,
      5'd31, 5'd31, 5'd4, 5'd2, 5'd1, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31,
      5'd31, 5'd31, 5'd0, 5'd31};

   // per-phase settings; each compare value sits near the middle of the lines
   // that phase typically covers, while 255 and 0 are never matched here
   logic [7:0] phase_enables [6] = '{8'h0F, 8'h00, 8'h0A, 8'h05, 8'h0F, 8'h08};
   logic [7:0] phase_compare [6] = '{8'd255, 8'd24, 8'd39, 8'd0, 8'd68, 8'd82};

   lcd_mode_timing_sequencer uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_elapsed_cycles (req_elapsed_cycles),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_lcd_mode       (rsp_lcd_mode),
      .rsp_current_line   (rsp_current_line),
      .rsp_coincidence    (rsp_coincidence),
      .rsp_vblank_irq     (rsp_vblank_irq),
      .rsp_lcd_irq        (rsp_lcd_irq),
      .rsp_render_line    (rsp_render_line),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #5 clock = ~clock;

   // gap length: mostly none or short, now and then long, with quiet runs
   function automatic int pick_gap(inout int quiet_left);
      int r;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      r = $urandom_range(0, 199);
      if (r == 0) quiet_left = $urandom_range(20, 80);
      if (r < 120) return 0;
      if (r < 180) return $urandom_range(1, 3);
      if (r < 196) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // line advance with compare; returns the line-compare interrupt
   function automatic logic advance_line();
      pred_line  = pred_line + 8'd1;
      pred_coinc = (pred_line == cfg_compare);
      return pred_coinc && cfg_enables[lmts_pkg::EN_LYC];
   endfunction

   // one tick item: saturating add, then at most one mode transition
   function automatic lcd_status_type predict_step(input logic [4:0] ticks);
      lcd_status_type st;
      logic [16:0] sum;
      st     = '0;
      sum    = {1'b0, acc_cycles} + {12'd0, ticks};
      acc_cycles = sum[16] ? 16'hFFFF : sum[15:0];
      case (pred_mode)
         lmts_pkg::MODE_HBLANK: begin
            if (acc_cycles >= lmts_pkg::DUR_HBLANK) begin
               acc_cycles = acc_cycles - lmts_pkg::DUR_HBLANK;
               st.lcd = advance_line();
               if (pred_line == lmts_pkg::LINE_VBLANK) begin
                  pred_mode = lmts_pkg::MODE_VBLANK;
                  st.vblank = 1'b1;
                  if (cfg_enables[lmts_pkg::EN_VBLANK]) st.lcd = 1'b1;
               end else begin
                  pred_mode = lmts_pkg::MODE_OAM;
                  if (cfg_enables[lmts_pkg::EN_OAM]) st.lcd = 1'b1;
               end
            end
         end
         lmts_pkg::MODE_VBLANK: begin
            if (acc_cycles >= lmts_pkg::DUR_VLINE) begin
               acc_cycles = acc_cycles - lmts_pkg::DUR_VLINE;
               st.lcd = advance_line();
               // compare already done with the last line before the wrap
               if (pred_line == lmts_pkg::LINE_LAST) begin
                  pred_line = '0;
                  pred_mode = lmts_pkg::MODE_OAM;
                  if (cfg_enables[lmts_pkg::EN_OAM]) st.lcd = 1'b1;
               end
            end
         end
         lmts_pkg::MODE_OAM: begin
            if (acc_cycles >= lmts_pkg::DUR_OAM) begin
               acc_cycles = acc_cycles - lmts_pkg::DUR_OAM;
               pred_mode  = lmts_pkg::MODE_XFER;
            end
         end
         default: begin
            if (acc_cycles >= lmts_pkg::DUR_XFER) begin
               acc_cycles = acc_cycles - lmts_pkg::DUR_XFER;
               pred_mode  = lmts_pkg::MODE_HBLANK;
               st.render  = 1'b1;
               if (cfg_enables[lmts_pkg::EN_HBLANK]) st.lcd = 1'b1;
            end
         end
      endcase
      st.mode  = pred_mode;
      st.line  = pred_line;
      st.coinc = pred_coinc;
      return st;
   endfunction

   function automatic void check_field(string field, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endfunction

   task automatic queue_tick(input logic [4:0] ticks);
      pending_op_type op;
      op.kind  = OP_TICK;
      op.ticks = ticks;
      op.index = '0;
      op.data  = '0;
      pending_ops.push_back(op);
   endtask

   task automatic queue_csr(input logic [7:0] index, input logic [7:0] data);
      pending_op_type op;
      op.kind  = OP_CSR;
      op.ticks = '0;
      op.index = index;
      op.data  = data;
      pending_ops.push_back(op);
   endtask

   // driver: tick items and register writes; writes wait for an idle block
   always @(posedge clock) begin : drive_items
      logic next_valid;
      logic next_csr;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         next_valid = req_valid && req_stall;
         next_csr   = csr_valid && !csr_ready;
         if (req_valid && !req_stall) begin
            line_status_q.push_back(predict_step(req_elapsed_cycles));
            tick_gap = pick_gap(tx_quiet);
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == lmts_pkg::CSR_STAT_IRQ_ENABLES) begin
               cfg_enables = csr_data[3:0];
            end else if (csr_index == lmts_pkg::CSR_COMPARE_LINE) begin
               cfg_compare = csr_data;
            end
         end
         if (line_status_q.size() == 0 && !next_valid) settle_count++;
         else settle_count = 0;
         if (!next_valid && !next_csr) begin
            if (tick_gap > 0) begin
               tick_gap--;
            end else if (pending_ops.size() != 0) begin
               if (pending_ops[0].kind == OP_TICK) begin
                  req_elapsed_cycles <= pending_ops[0].ticks;
                  next_valid = 1'b1;
                  void'(pending_ops.pop_front());
               end else if (settle_count >= SETTLE_CYCLES) begin
                  csr_index <= pending_ops[0].index;
                  csr_data  <= pending_ops[0].data;
                  next_csr  = 1'b1;
                  void'(pending_ops.pop_front());
               end
            end
         end
         req_valid <= next_valid;
         csr_valid <= next_csr;
      end
   end

   // monitor: check status items and drive receiver stalls
   always @(posedge clock) begin : check_status
      lcd_status_type want;
      logic           next_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (line_status_q.size() == 0) begin
               $error("status item with none expected: line %0d", rsp_current_line);
               mismatches++;
            end else begin
               want = line_status_q.pop_front();
               check_field("lcd_mode", want.mode, rsp_lcd_mode);
               check_field("current_line", want.line, rsp_current_line);
               check_field("coincidence", want.coinc, rsp_coincidence);
               check_field("vblank_irq", want.vblank, rsp_vblank_irq);
               check_field("lcd_irq", want.lcd, rsp_lcd_irq);
               check_field("render_line", want.render, rsp_render_line);
            end
            results_seen++;
            // one long hold-off so the block backs up into its input
            if (results_seen == HOLD_AT_ITEM) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
         end else if (stall_gap > 0) begin
            stall_gap--;
            next_stall = 1'b1;
         end else begin
            next_stall = 1'b0;
            stall_gap  = pick_gap(rx_quiet);
         end
         rsp_stall <= next_stall;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      queue_csr(lmts_pkg::CSR_STAT_IRQ_ENABLES, 8'h0F);
      queue_csr(lmts_pkg::CSR_COMPARE_LINE, 8'd1);
      foreach (opening_ticks[i]) queue_tick(opening_ticks[i]);
      for (int p = 0; p < 6; p++) begin
         queue_csr(lmts_pkg::CSR_STAT_IRQ_ENABLES, phase_enables[p]);
         queue_csr(lmts_pkg::CSR_COMPARE_LINE, phase_compare[p]);
         // mostly large ticks so that many lines go by
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 8) queue_tick(5'($urandom_range(20, 31)));
            else queue_tick(5'($urandom_range(0, 31)));
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // wait for the queues to drain, sampled away from the active edge
      @(negedge clock);
      while (pending_ops.size() != 0 || req_valid || csr_valid ||
             line_status_q.size() != 0)
         @(negedge clock);
      repeat (5) @(posedge clock);

      if (line_status_q.size() != 0) begin
         $error("%0d status items never arrived", line_status_q.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/lmts_pkg.sv
design/lcd_mode_timing_sequencer.sv
tb/tb_lcd_mode_timing_sequencer.sv
